@@ rtl/sstg_pkg.sv @@
package sstg_pkg;

   // field widths
   localparam int FREQ_W = 19;
   localparam int DUR_W  = 24;
   localparam int PERM_W = 12;
   localparam int TIME_W = 25;

   // product of frequency and sweep factor
   localparam int DIV_W = FREQ_W + PERM_W;
   localparam int CNT_W = 5;

   // division by 1000 as a shift by 3 and a reciprocal multiply for 125
   localparam int SCALE_SHIFT = 3;
   localparam int RECIP_W     = 29;
   localparam int RECIP_SHIFT = 35;
   localparam int MUL_W       = DIV_W - SCALE_SHIFT + RECIP_W;
   localparam int QUOT_W      = MUL_W - RECIP_SHIFT;
   localparam logic [RECIP_W-1:0] RECIP_125 = 29'd274877907;

   // arithmetic constants
   localparam logic [FREQ_W-1:0] HALF_SECOND_TICKS = 19'd500000;
   localparam logic [FREQ_W-1:0] FREQ_MAX          = 19'd500000;
   localparam logic [FREQ_W-1:0] FREQ_MIN          = 19'd1;
   localparam logic [FREQ_W-1:0] PERMILLE          = 19'd1000;
   localparam logic [PERM_W-1:0] FACTOR_RESET      = 12'd1000;

   // iteration count of the divider
   localparam logic [CNT_W-1:0] HP_ITERS = CNT_W'(FREQ_W);

   // item kinds
   localparam logic KIND_START = 1'b0;
   localparam logic KIND_TICK  = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HP_LOAD,
      ST_HP_RUN,
      ST_FREQ_LOAD,
      ST_FREQ_RUN
   } state_type;

   typedef struct packed {
      logic                kind;
      logic [FREQ_W-1:0]   start_freq;
      logic [DUR_W-1:0]    duration_us;
      logic [PERM_W-1:0]   sweep_permille;
   } req_item_type;

   typedef struct packed {
      logic load_item;
      logic div_load_hp;
      logic write_hp;
      logic scale_freq;
      logic write_freq;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic need_period;
      logic div_done;
   } status_type;

endpackage

@@ rtl/sstg_req_if.sv @@
interface sstg_req_if;
   logic                          valid;
   logic                          ready;
   logic                          kind;
   logic [sstg_pkg::FREQ_W-1:0]   start_freq;
   logic [sstg_pkg::DUR_W-1:0]    duration_us;
   logic [sstg_pkg::PERM_W-1:0]   sweep_permille;

   modport source (
      output valid, kind, start_freq, duration_us, sweep_permille,
      input  ready
   );
   modport sink (
      input  valid, kind, start_freq, duration_us, sweep_permille,
      output ready
   );
endinterface

@@ rtl/sstg_rsp_if.sv @@
interface sstg_rsp_if;
   logic valid;
   logic ready;
   logic pin_level;
   logic busy_res;

   modport source (
      output valid, pin_level, busy_res,
      input  ready
   );
   modport sink (
      input  valid, pin_level, busy_res,
      output ready
   );
endinterface

@@ rtl/swept_square_tone_generator.sv @@
// Square-wave tone generator with an exponential frequency sweep. A start item
// (kind 0) loads the frequency, the duration in microseconds and the sweep
// factor in thousandths; a tick item (kind 1) advances time by one microsecond
// and each item returns the pin level and busy flag after it. An item that does
// not begin a new period is answered in the cycle after it is taken. An item
// that begins a period (a start with nonzero duration, or a tick at the end of a
// low half while time remains) passes the divider load, divider run, scale and
// write-back states: the radix-2 divider runs 19 iterations for the half period,
// and the frequency is scaled by the sweep factor with the division by 1000 done
// as a registered reciprocal multiply. One item is in work at a time; the next
// is taken once the result has been accepted or is being accepted.
module swept_square_tone_generator (
   input logic         clock,
   input logic         reset,
   sstg_req_if.sink    req_ch,
   sstg_rsp_if.source  rsp_ch
);
   import sstg_pkg::*;

   cmd_type      cmd;
   status_type   status;
   req_item_type req_item;

   // gather the request payload
   assign req_item.kind           = req_ch.kind;
   assign req_item.start_freq     = req_ch.start_freq;
   assign req_item.duration_us    = req_ch.duration_us;
   assign req_item.sweep_permille = req_ch.sweep_permille;

   sstg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   sstg_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .cmd       (cmd),
      .status    (status),
      .pin_level (rsp_ch.pin_level),
      .busy_res  (rsp_ch.busy_res)
   );

endmodule

@@ rtl/sstg_ctrl.sv @@
module sstg_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  sstg_pkg::status_type status,
   output sstg_pkg::cmd_type    cmd
);
   import sstg_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;

   // a new item is taken only when idle and the result slot is free or draining
   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && status.need_period) state_in = ST_HP_LOAD;
         end
         ST_HP_LOAD: state_in = ST_HP_RUN;
         ST_HP_RUN: begin
            if (status.div_done) state_in = ST_FREQ_LOAD;
         end
         ST_FREQ_LOAD: state_in = ST_FREQ_RUN;
         ST_FREQ_RUN: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // command outputs
   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.load_item = accept;
            cmd.rsp_load  = accept && !status.need_period;
         end
         ST_HP_LOAD: cmd.div_load_hp = 1'b1;
         ST_HP_RUN: cmd.write_hp = status.div_done;
         ST_FREQ_LOAD: cmd.scale_freq = 1'b1;
         ST_FREQ_RUN: begin
            cmd.write_freq = 1'b1;
            cmd.rsp_load   = 1'b1;
         end
         default: cmd = '0;
      endcase
   end

   // result valid flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ rtl/sstg_dp.sv @@
module sstg_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  sstg_pkg::req_item_type req_item,
   input  sstg_pkg::cmd_type      cmd,
   output sstg_pkg::status_type   status,
   output logic                   pin_level,
   output logic                   busy_res
);
   import sstg_pkg::*;

   // tone state
   logic              active_ff, active_in;
   logic              level_ff, level_in;
   logic [TIME_W-1:0] elapsed_ff, elapsed_in;
   logic [TIME_W-1:0] next_edge_ff, next_edge_in;
   logic [DUR_W-1:0]  end_ff, end_in;
   logic [FREQ_W-1:0] half_ff, half_in;
   logic [FREQ_W-1:0] freq_ff, freq_in;
   logic [PERM_W-1:0] factor_ff, factor_in;
   logic [DIV_W-1:0]  product_ff, product_in;

   // divider
   logic [FREQ_W-1:0] div_quot_ff, div_quot_in;
   logic [FREQ_W-1:0] div_rem_ff, div_rem_in;
   logic [FREQ_W-1:0] divisor_ff, divisor_in;
   logic [CNT_W-1:0]  div_cnt_ff, div_cnt_in;
   logic [FREQ_W:0]   rem_shift;
   logic [FREQ_W:0]   rem_diff;
   logic              rem_fits;

   // frequency scaling
   logic [MUL_W-1:0]  scaled_ff, scaled_in;
   logic [QUOT_W-1:0] scaled_q;

   // result payload
   logic              pin_ff, busy_ff;

   logic [TIME_W-1:0] elapsed_inc;
   logic [FREQ_W-1:0] start_freq_sat;
   logic [FREQ_W-1:0] hp_q;
   logic [FREQ_W-1:0] freq_q;
   logic              need_period;

   // tick arithmetic
   assign elapsed_inc = elapsed_ff + TIME_W'(1);

   // saturate the requested start frequency
   always_comb begin
      if (req_item.start_freq == '0) start_freq_sat = FREQ_MIN;
      else if (req_item.start_freq > FREQ_MAX) start_freq_sat = FREQ_MAX;
      else start_freq_sat = req_item.start_freq;
   end

   // a period begins on a start with nonzero duration, or on a tick at a rising
   // edge while time remains
   always_comb begin
      if (req_item.kind == KIND_START) begin
         need_period = (req_item.duration_us != '0);
      end else begin
         need_period = active_ff && (elapsed_inc >= next_edge_ff) && !level_ff
                       && ({1'b0, end_ff} > elapsed_inc);
      end
   end

   // half period from the quotient, at least one tick
   always_comb begin
      hp_q = div_quot_ff;
      if (hp_q == '0) hp_q = FREQ_MIN;
   end

   // new frequency from the scaled product, saturated
   assign scaled_q = scaled_ff[MUL_W-1:RECIP_SHIFT];

   always_comb begin
      if (scaled_q == '0) freq_q = FREQ_MIN;
      else if (scaled_q > QUOT_W'(FREQ_MAX)) freq_q = FREQ_MAX;
      else freq_q = scaled_q[FREQ_W-1:0];
   end

   // tone state update
   always_comb begin
      active_in    = active_ff;
      level_in     = level_ff;
      elapsed_in   = elapsed_ff;
      next_edge_in = next_edge_ff;
      end_in       = end_ff;
      half_in      = half_ff;
      freq_in      = freq_ff;
      factor_in    = factor_ff;
      product_in   = product_ff;
      if (cmd.load_item) begin
         if (req_item.kind == KIND_START) begin
            freq_in      = start_freq_sat;
            end_in       = req_item.duration_us;
            factor_in    = req_item.sweep_permille;
            elapsed_in   = '0;
            next_edge_in = '0;
            active_in    = (req_item.duration_us != '0);
            if (req_item.duration_us == '0) level_in = 1'b0;
         end else if (active_ff) begin
            elapsed_in = elapsed_inc;
            if (elapsed_inc >= next_edge_ff) begin
               if (level_ff) begin
                  level_in     = 1'b0;
                  next_edge_in = next_edge_ff + TIME_W'(half_ff);
               end else if (!need_period) begin
                  active_in = 1'b0;
               end
            end
         end
      end
      if (cmd.write_hp) begin
         half_in      = hp_q;
         next_edge_in = next_edge_ff + TIME_W'(hp_q);
         level_in     = 1'b1;
         product_in   = DIV_W'(freq_ff) * DIV_W'(factor_ff);
      end
      if (cmd.write_freq) freq_in = freq_q;
   end

   // radix-2 restoring divider for the half period, one quotient bit per cycle
   assign rem_shift = {div_rem_ff, div_quot_ff[FREQ_W-1]};
   assign rem_fits  = (rem_shift >= {1'b0, divisor_ff});
   assign rem_diff  = rem_shift - {1'b0, divisor_ff};

   always_comb begin
      div_quot_in = div_quot_ff;
      div_rem_in  = div_rem_ff;
      divisor_in  = divisor_ff;
      div_cnt_in  = div_cnt_ff;
      if (cmd.div_load_hp) begin
         div_quot_in = HALF_SECOND_TICKS;
         div_rem_in  = '0;
         divisor_in  = freq_ff;
         div_cnt_in  = HP_ITERS;
      end else if (div_cnt_ff != '0) begin
         div_quot_in = {div_quot_ff[FREQ_W-2:0], rem_fits};
         div_rem_in  = rem_fits ? rem_diff[FREQ_W-1:0] : rem_shift[FREQ_W-1:0];
         div_cnt_in  = div_cnt_ff - CNT_W'(1);
      end
   end

   // product divided by 1000: drop three bits, then multiply by the reciprocal of 125
   always_comb begin
      scaled_in = scaled_ff;
      if (cmd.scale_freq) begin
         scaled_in = MUL_W'(product_ff[DIV_W-1:SCALE_SHIFT]) * MUL_W'(RECIP_125);
      end
   end

   assign status.need_period = need_period;
   assign status.div_done    = (div_cnt_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         level_ff     <= 1'b0;
         elapsed_ff   <= '0;
         next_edge_ff <= '0;
         end_ff       <= '0;
         half_ff      <= '0;
         freq_ff      <= FREQ_MIN;
         factor_ff    <= FACTOR_RESET;
         div_cnt_ff   <= '0;
      end else begin
         active_ff    <= active_in;
         level_ff     <= level_in;
         elapsed_ff   <= elapsed_in;
         next_edge_ff <= next_edge_in;
         end_ff       <= end_in;
         half_ff      <= half_in;
         freq_ff      <= freq_in;
         factor_ff    <= factor_in;
         div_cnt_ff   <= div_cnt_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      product_ff  <= product_in;
      div_quot_ff <= div_quot_in;
      div_rem_ff  <= div_rem_in;
      divisor_ff  <= divisor_in;
      scaled_ff   <= scaled_in;
      if (cmd.rsp_load) begin
         pin_ff  <= level_in;
         busy_ff <= active_in;
      end
   end

   assign pin_level = pin_ff;
   assign busy_res  = busy_ff;

endmodule

@@ bench/swept_square_tone_generator_test.sv @@
`timescale 1ns / 100ps

module swept_square_tone_generator_test;

   import sstg_pkg::*;

   localparam int RANDOM_ITEMS   = 1700;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int DRAIN_CYCLES   = 80;
   localparam int REPORT_LIMIT   = 10;
   localparam int DIRECTED_COUNT = 25;

   typedef struct packed {
      logic pin_level;
      logic busy_res;
   } tone_result_type;

   // one stimulus row: the item, and a typed-in result where it is obvious
   typedef struct packed {
      req_item_type    item;
      logic            typed;
      tone_result_type result;
   } stim_row_type;

   typedef enum int {
      RSP_ALWAYS,
      RSP_MOSTLY,
      RSP_HALF,
      RSP_SPARSE
   } rsp_stall_mode_type;

   // directed items: idle ticks, extreme fields, zero frequency, zero duration,
   // start while busy, zero sweep and a one microsecond tone
   localparam stim_row_type DIRECTED [DIRECTED_COUNT] = '{
      '{'{KIND_TICK,  19'd0,      24'd0,        12'd0},    1'b1, '{1'b0, 1'b0}},
      '{'{KIND_START, 19'd500000, 24'd3,        12'd1000}, 1'b1, '{1'b1, 1'b1}},
      '{'{KIND_TICK,  19'd0,      24'd0,        12'd0},    1'b0, '{1'b0, 1'b0}},
      '{'{KIND_TICK,  19'd0,      24'd0,        12'd0},    1'b0, '{1'b0, 1'b0}},
      '{'{KIND_TICK,  19'd0,      24'd0,        12'd0},    1'b0, '{1'b0, 1'b0}},
      '{'{KIND_TICK,  19'd0,      24'd0,        12'd0},    1'b0, '{1'b0, 1'b0}},
      '{'{KIND_TICK,  19'd0,      24'd0,        12'd0},    1'b1, '{1'b0, 1'b0}},
      '{'{KIND_START, 19'd0,      24'd10,       12'd0},    1'b1, '{1'b1, 1'b1}},
      '{'{KIND_TICK,  19'd0,      24'd0,        12'd0},    1'b0, '{1'b0, 1'b0}},
      '{'{KIND_START, 19'h7FFFF,  24'hFFFFFF,   12'd4095}, 1'b1, '{1'b1, 1'b1}},
      '{'{KIND_TICK,  19'd0,      24'd0,        12'd0},    1'b0, '{1'b0, 1'b0}},
      '{'{KIND_TICK,  19'd0,      24'd0,        12'd0},    1'b0, '{1'b0, 1'b0}},
      '{'{KIND_TICK,  19'd0,      24'd0,        12'd0},    1'b0, '{1'b0, 1'b0}},
      '{'{KIND_START, 19'd1000,   24'd0,        12'd1000}, 1'b1, '{1'b0, 1'b0}},
      '{'{KIND_TICK,  19'h7FFFF,  24'hFFFFFF,   12'hFFF},  1'b1, '{1'b0, 1'b0}},
      '{'{KIND_START, 19'd500000, 24'd4,        12'd0},    1'b1, '{1'b1, 1'b1}},
      '{'{KIND_TICK,  19'd0,      24'd0,        12'd0},    1'b0, '{1'b0, 1'b0}},
      '{'{KIND_TICK,  19'd0,      24'd0,        12'd0},    1'b0, '{1'b0, 1'b0}},
      '{'{KIND_TICK,  19'd0,      24'd0,        12'd0},    1'b0, '{1'b0, 1'b0}},
      '{'{KIND_START, 19'd250000, 24'd20,       12'd500},  1'b1, '{1'b1, 1'b1}},
      '{'{KIND_TICK,  19'd0,      24'd0,        12'd0},    1'b0, '{1'b0, 1'b0}},
      '{'{KIND_TICK,  19'd0,      24'd0,        12'd0},    1'b0, '{1'b0, 1'b0}},
      '{'{KIND_TICK,  19'd0,      24'd0,        12'd0},    1'b0, '{1'b0, 1'b0}},
      '{'{KIND_TICK,  19'd0,      24'd0,        12'd0},    1'b0, '{1'b0, 1'b0}},
      '{'{KIND_START, 19'd999,    24'd1,        12'd2000}, 1'b1, '{1'b1, 1'b1}}
   };

   logic clock;
   logic reset;

   sstg_req_if req_ch ();
   sstg_rsp_if rsp_ch ();

   swept_square_tone_generator dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   // tone state as the block should hold it
   logic                tone_active  = 1'b0;
   logic                tone_level   = 1'b0;
   logic [TIME_W-1:0]   tone_elapsed = '0;
   logic [TIME_W-1:0]   tone_edge    = '0;
   logic [DUR_W-1:0]    tone_end     = '0;
   logic [FREQ_W-1:0]   tone_half    = '0;
   logic [FREQ_W-1:0]   tone_freq    = FREQ_MIN;
   logic [PERM_W-1:0]   tone_factor  = FACTOR_RESET;

   tone_result_type pin_states_due [$];
   stim_row_type    drive_row;
   int              sent_items     = 0;
   int              result_count   = 0;
   int              mismatch_count = 0;
   int              burst_left     = 0;

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [FREQ_W-1:0] limit_freq(input logic [DIV_W-1:0] freq);
      if (freq < DIV_W'(FREQ_MIN)) begin
         return FREQ_MIN;
      end
      if (freq > DIV_W'(FREQ_MAX)) begin
         return FREQ_MAX;
      end
      return freq[FREQ_W-1:0];
   endfunction

   // half period from the current frequency, then sweep the frequency
   task automatic open_period(input logic [TIME_W-1:0] base);
      logic [DIV_W-1:0] scaled;
      tone_half = HALF_SECOND_TICKS / tone_freq;
      if (tone_half == '0) begin
         tone_half = FREQ_W'(1);
      end
      scaled = (DIV_W'(tone_freq) * DIV_W'(tone_factor)) / DIV_W'(PERMILLE);
      tone_freq = limit_freq(scaled);
      tone_level = 1'b1;
      tone_edge = base + TIME_W'(tone_half);
   endtask

   task automatic play_tone_item(input req_item_type it, output tone_result_type res);
      if (it.kind == KIND_START) begin
         tone_freq = limit_freq(DIV_W'(it.start_freq));
         tone_end = it.duration_us;
         tone_factor = it.sweep_permille;
         tone_elapsed = '0;
         tone_edge = '0;
         if (tone_end != '0) begin
            tone_active = 1'b1;
            open_period('0);
         end else begin
            tone_active = 1'b0;
            tone_level = 1'b0;
         end
      end else if (tone_active) begin
         tone_elapsed = tone_elapsed + TIME_W'(1);
         if (tone_elapsed >= tone_edge) begin
            if (tone_level) begin
               tone_level = 1'b0;
               tone_edge = tone_edge + TIME_W'(tone_half);
            end else if (TIME_W'(tone_end) > tone_elapsed) begin
               open_period(tone_edge);
            end else begin
               tone_active = 1'b0;
            end
         end
      end
      res.pin_level = tone_level;
      res.busy_res = tone_active;
   endtask

   // predict on each accepted item, check each accepted result
   always @(posedge clock) begin
      req_item_type    it;
      tone_result_type predicted;
      tone_result_type want;
      tone_result_type got;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            it.kind = req_ch.kind;
            it.start_freq = req_ch.start_freq;
            it.duration_us = req_ch.duration_us;
            it.sweep_permille = req_ch.sweep_permille;
            sent_items++;
            play_tone_item(it, predicted);
            pin_states_due.push_back(drive_row.typed ? drive_row.result : predicted);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.pin_level = rsp_ch.pin_level;
            got.busy_res = rsp_ch.busy_res;
            if (pin_states_due.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $display("result %0d arrived with nothing expected: pin %0b busy %0b",
                           result_count, got.pin_level, got.busy_res);
               end
            end else begin
               want = pin_states_due.pop_front();
               if (got.pin_level !== want.pin_level || got.busy_res !== want.busy_res) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT) begin
                     $display("result %0d: expected pin %0b busy %0b, got pin %0b busy %0b",
                              result_count, want.pin_level, want.busy_res,
                              got.pin_level, got.busy_res);
                  end
               end
            end
            result_count++;
         end
      end
   end

   // receiver stalls, switching between patterns
   initial begin : rsp_stall
      rsp_stall_mode_type mode;
      int                 left;
      rsp_ch.ready = 1'b0;
      mode = RSP_ALWAYS;
      left = 0;
      forever begin
         @(negedge clock);
         if (left == 0) begin
            mode = rsp_stall_mode_type'($urandom_range(3));
            left = $urandom_range(20, 300);
         end
         left--;
         case (mode)
            RSP_ALWAYS: rsp_ch.ready = 1'b1;
            RSP_MOSTLY: rsp_ch.ready = ($urandom_range(3) != 0);
            RSP_HALF:   rsp_ch.ready = ($urandom_range(1) == 1);
            default:    rsp_ch.ready = ($urandom_range(9) == 0);
         endcase
      end
   end

   // ends the run when nothing moves for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // drive one item in bursts with random gaps, return after it is accepted
   task automatic send_item(input stim_row_type row);
      if (burst_left == 0) begin
         req_ch.valid = 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
         burst_left = ($urandom_range(7) == 0) ? 200 : $urandom_range(1, 30);
      end
      burst_left--;
      drive_row = row;
      req_ch.kind = row.item.kind;
      req_ch.start_freq = row.item.start_freq;
      req_ch.duration_us = row.item.duration_us;
      req_ch.sweep_permille = row.item.sweep_permille;
      req_ch.valid = 1'b1;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
   endtask

   function automatic stim_row_type random_tick();
      stim_row_type row;
      row = '0;
      row.item.kind = KIND_TICK;
      row.item.start_freq = FREQ_W'($urandom);
      row.item.duration_us = DUR_W'($urandom);
      row.item.sweep_permille = PERM_W'($urandom);
      return row;
   endfunction

   // stimulus
   initial begin
      stim_row_type row;
      int           random_base;
      int           span;
      int           ticks;
      reset = 1'b1;
      drive_row = '0;
      req_ch.valid = 1'b0;
      req_ch.kind = KIND_TICK;
      req_ch.start_freq = '0;
      req_ch.duration_us = '0;
      req_ch.sweep_permille = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         send_item(DIRECTED[i]);
      end

      // mostly whole tones with random content, some noise
      random_base = sent_items;
      while (sent_items - random_base < RANDOM_ITEMS) begin
         if ($urandom_range(99) < 85) begin
            row = '0;
            row.item.kind = KIND_START;
            case ($urandom_range(9))
               0:       row.item.start_freq = FREQ_W'($urandom_range(1, 20000));
               1:       row.item.start_freq = FREQ_W'($urandom);
               default: row.item.start_freq = FREQ_W'($urandom_range(15000, 500000));
            endcase
            row.item.sweep_permille = $urandom_range(1) ? PERM_W'($urandom_range(900, 1100))
                                                        : PERM_W'($urandom);
            case ($urandom_range(19))
               0:       row.item.duration_us = DUR_W'($urandom);
               1, 2:    row.item.duration_us = DUR_W'($urandom_range(121, 400));
               default: row.item.duration_us = DUR_W'($urandom_range(1, 120));
            endcase
            span = (row.item.duration_us > 400) ? 400 : int'(row.item.duration_us);
            ticks = $urandom_range(1, span + 40);
            send_item(row);
            repeat (ticks) send_item(random_tick());
         end else begin
            repeat ($urandom_range(1, 5)) begin
               row = random_tick();
               if ($urandom_range(1)) begin
                  row.item.kind = KIND_START;
               end
               send_item(row);
            end
         end
      end
      req_ch.valid = 1'b0;

      // let every result come back, then allow for stragglers
      while (pin_states_due.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && pin_states_due.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/sstg_pkg.sv
rtl/sstg_req_if.sv
rtl/sstg_rsp_if.sv
rtl/sstg_ctrl.sv
rtl/sstg_dp.sv
rtl/swept_square_tone_generator.sv
bench/swept_square_tone_generator_test.sv
